@@ rtl/bounded_deque_with_search_top_defines.svh @@
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/bdq_pkg.sv @@
// Operation and status codes of the bounded deque.
package bdq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

endpackage

@@ rtl/bdq_if.sv @@
// Request and response channel interfaces of the bounded deque.
interface bdq_req_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               operation;
  logic signed [31:0]       value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int unsigned CNT_W = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [31:0]       data_out;
  logic [CNT_W-1:0]         position;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, output status, output data_out, output position,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input data_out, input position,
                  input occupancy, output ready);
endinterface

@@ rtl/bdq_store.sv @@
// Ring store of the deque: one write port and one registered read port.
module bdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic [bdq_pkg::DataW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic [bdq_pkg::DataW-1:0] rdata_o
);
  import bdq_pkg::*;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bounded_deque_with_search_top.sv @@
// Bounded double-ended queue of signed 32-bit values with a linear search.
// Values sit in a ring store of DEPTH entries with a single read port; one ring
// address adder serves back pushes, pops and searches (front pushes use a
// decrement) and one 32-bit comparator serves searches, under a small
// sequencer; the block takes one request at a time. Inserts, rejected requests
// and unused codes go straight to the finish state, deletes first pass one
// registered store read, and a search reads held entries in order up to the
// first match, or all of them on a miss, the read port delivering one entry per
// cycle to the comparator. A new request is taken the cycle after the response
// register is loaded, even while that response still waits to be taken. Unused
// operation codes change nothing and answer done with the current occupancy.
// No clearing pass follows reset: only entries that were written are ever read.
`include "bounded_deque_with_search_top_defines.svh"

module bounded_deque_with_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdq_req_if.sink      req_i,
  bdq_rsp_if.source    rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0]   DepthWide = (IdxW + 1)'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Front plus offset, wrapped into the ring; both operands stay below DEPTH.
  function automatic logic [IdxW-1:0] ring_add(logic [IdxW-1:0] base,
                                               logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthWide) begin
      sum = sum - DepthWide;
    end
    return sum[IdxW-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [DataW-1:0] val_q, val_d;
  status_e          res_status_q, res_status_d;
  logic [DataW-1:0] res_data_q, res_data_d;
  logic [CntW-1:0]  res_pos_q, res_pos_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic [DataW-1:0] out_data_q;
  logic [CntW-1:0]  out_pos_q;
  logic [CntW-1:0]  out_occ_q;
  logic             out_load;

  logic             accept;
  logic             full;
  logic             empty;
  logic [IdxW-1:0]  cnt_lo;
  logic [IdxW-1:0]  back_off;
  logic [IdxW-1:0]  front_dec;
  logic [IdxW-1:0]  next_idx;
  logic [CntW-1:0]  next_pos;
  logic [IdxW-1:0]  unit_off;
  logic [IdxW-1:0]  unit_addr;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [DataW-1:0] mem_rdata;

  assign accept    = req_i.valid && req_i.ready;
  assign full      = (count_q == DepthCnt);
  assign empty     = (count_q == '0);
  assign cnt_lo    = count_q[IdxW-1:0];
  assign back_off  = IdxW'(count_q - CntW'(1));
  assign front_dec = (front_q == '0) ? LastIdx : (front_q - IdxW'(1));
  assign next_idx  = cmp_idx_q + IdxW'(1);
  assign next_pos  = CntW'(cmp_idx_q) + CntW'(1);

  // Shared ring address unit: pick the offset the current step needs.
  always_comb begin
    unit_off = next_idx;
    if (state_q == S_IDLE) begin
      unique case (req_i.operation)
        OP_PUSH_BACK: unit_off = cnt_lo;
        OP_POP_FRONT: unit_off = IdxW'(1);
        OP_POP_BACK:  unit_off = back_off;
        default:      unit_off = '0;
      endcase
    end
  end

  assign unit_addr = ring_add(front_q, unit_off);

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    cmp_idx_d    = cmp_idx_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_pos_d    = res_pos_q;
    mem_we       = 1'b0;
    mem_waddr    = unit_addr;
    mem_re       = 1'b0;
    mem_raddr    = unit_addr;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d        = req_i.value;
          res_status_d = ST_DONE;
          res_data_d   = '0;
          res_pos_d    = '0;
          state_d      = S_FIN;
          unique case (req_i.operation)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                front_d   = front_dec;
                count_d   = count_q + CntW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                front_d   = unit_addr;
                count_d   = count_q - CntW'(1);
                state_d   = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                count_d = count_q - CntW'(1);
                state_d = S_READ;
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = front_q;
                cmp_idx_d = '0;
                state_d   = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_data_d = mem_rdata;
        state_d    = S_FIN;
      end
      S_SRCH: begin
        // Compare the entry read last cycle while fetching the next one.
        if (mem_rdata == val_q) begin
          res_status_d = ST_DONE;
          res_pos_d    = next_pos;
          state_d      = S_FIN;
        end else if (next_pos == count_q) begin
          res_status_d = ST_MISS;
          state_d      = S_FIN;
        end else begin
          mem_re    = 1'b1;
          cmp_idx_d = next_idx;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_pos_q    <= res_pos_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_pos_q    <= res_pos_q;
      out_occ_q    <= count_q;
    end
  end

  bdq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_d),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.data_out  = out_data_q;
  assign rsp_o.position  = out_pos_q;
  assign rsp_o.occupancy = out_occ_q;

  `BDQ_ASSERT(a_count_bound, count_q <= DepthCnt, "entry count beyond depth")
  `BDQ_ASSERT(a_srch_live, (state_q == S_SRCH) |-> (next_pos <= count_q), "search past live region")
  `BDQ_ASSERT_NEXT(a_push_count, accept && (req_i.operation == OP_PUSH_BACK) && !full, count_q == $past(count_q) + CntW'(1), "push did not grow count")
  `BDQ_ASSERT_NEXT(a_occ_match, out_load, rsp_o.occupancy == count_q, "reported occupancy stale")

endmodule
